[hw/rtl/wbc_pkg.sv]
// Shared types, constants and helper functions of the waypoint to Bezier converter.
package wbc_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_W = 32;
  localparam int SEG_TIME_W = 24;
  localparam int IDX_W = 12;
  localparam int STAT_W = 2;
  localparam int NUM_LANES = 3;
  localparam int NUM_SLOTS = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = COORD_W + SEG_TIME_W + 1;
  localparam int OFS_W = 40;
  localparam int DIV_CHUNK = 8;
  localparam int DIV_STAGES = OFS_W / DIV_CHUNK;
  localparam int OFS_LAT = DIV_STAGES + 3;
  localparam int PIPE_DEPTH = OFS_LAT + 1;
  localparam int SUM_W = OFS_W + 2;

  localparam int VEL_BIAS = 98304;
  localparam int VEL_SHIFT = 16;
  localparam int DIV3_BIAS = 1;
  localparam int DIV6_BIAS = 3;

  localparam logic [SEG_TIME_W-1:0] SEG_TIME_RST = 24'd32768;

  localparam logic [CFG_IDX_W-1:0] REG_SEG_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END_Z = 3'd6;

  localparam logic [1:0] OFS_DIV3 = 2'd0;
  localparam logic [1:0] OFS_DIV6 = 2'd1;
  localparam logic [1:0] OFS_VEL = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOO_FEW = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_MANY = 2'd2;

  localparam logic [2:0] SLOT_AM = 3'd0;
  localparam logic [2:0] SLOT_AC = 3'd1;
  localparam logic [2:0] SLOT_AP = 3'd2;
  localparam logic [2:0] SLOT_BM = 3'd3;
  localparam logic [2:0] SLOT_BC = 3'd4;
  localparam logic [2:0] SLOT_ST = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      final_point;
  } wbc_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ctrl_x;
    logic signed [COORD_W-1:0] ctrl_y;
    logic signed [COORD_W-1:0] ctrl_z;
    logic [IDX_W-1:0]          ctrl_index;
    logic                      run_end;
    logic [STAT_W-1:0]         status;
  } wbc_out_t;

  typedef struct packed {
    logic       shift;
    logic [1:0] mode_a;
    logic [1:0] mode_b;
    logic       interior;
    logic       ovf;
  } wbc_lcmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pa;
    logic signed [OFS_W-1:0]   oa;
    logic signed [COORD_W-1:0] pb;
    logic signed [OFS_W-1:0]   ob;
  } wbc_lane_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [STAT_W-1:0]    status;
    logic [IDX_W-1:0]     idx_a;
    logic [IDX_W-1:0]     idx_b;
  } wbc_ctrl_t;

  function automatic logic [DIV_CHUNK+1:0] div3_chunk(input logic [1:0] rem_in,
                                                      input logic [DIV_CHUNK-1:0] chunk);
    logic [1:0] rem;
    logic [2:0] t;
    logic [DIV_CHUNK-1:0] q;
    rem = rem_in;
    q = '0;
    for (int i = DIV_CHUNK - 1; i >= 0; i--) begin
      t = {rem, chunk[i]};
      if (t >= 3'd3) begin
        q[i] = 1'b1;
        rem = 2'(t - 3'd3);
      end else begin
        rem = t[1:0];
      end
    end
    return {rem, q};
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32'sh7FFF_FFFF);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [2:0] first_slot(input logic [NUM_SLOTS-1:0] mask);
    logic [2:0] s;
    s = SLOT_AM;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        s = 3'(i);
      end
    end
    return s;
  endfunction

endpackage

[hw/rtl/waypoint_to_cubic_bezier_ctrl_core.sv]
// Waypoint to cubic Bezier control point converter, top level: window, three lanes, merge.
// An accepted request passes the control pipeline, the merge hold registers and the output
// register before its first control point; stages advance only when the merge stage takes a
// request, so later requests wait longer. A request gives 0 to 5 results (usually 3), sent in turn.
// Reset: synchronous, active low; clears point count, window, pipeline and output valids,
// loads segment time 32768 and zero velocities. No memory, no clearing pass.
module waypoint_to_cubic_bezier_ctrl_core import wbc_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  wbc_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output wbc_out_t               out_data,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [SEG_TIME_W-1:0]      seg_time_r;
  logic signed [COORD_W-1:0]  sv_r [NUM_LANES];
  logic signed [COORD_W-1:0]  ev_r [NUM_LANES];

  logic [CNT_W-1:0]           cnt_r;
  logic [IDX_W-1:0]           idx3_r;

  logic                       adv;
  logic                       acc;
  logic                       fin;
  logic                       ovf;
  logic                       n_ge1;
  logic                       n_ge2;
  logic                       sv_nz;
  logic                       ev_nz;

  logic signed [COORD_W-1:0]  pt [NUM_LANES];
  wbc_lcmd_t                  lcmd;
  wbc_lane_t [NUM_LANES-1:0]  lane_res;

  wbc_ctrl_t                  ctl_nxt;
  wbc_ctrl_t                  ctl_r [0:PIPE_DEPTH-1];
  logic                       pv_r  [0:PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_time_r <= SEG_TIME_RST;
      for (int l = 0; l < NUM_LANES; l++) begin
        sv_r[l] <= '0;
        ev_r[l] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEG_TIME: seg_time_r <= cfg_wdata[SEG_TIME_W-1:0];
        REG_START_X:  sv_r[0] <= cfg_wdata;
        REG_START_Y:  sv_r[1] <= cfg_wdata;
        REG_START_Z:  sv_r[2] <= cfg_wdata;
        REG_END_X:    ev_r[0] <= cfg_wdata;
        REG_END_Y:    ev_r[1] <= cfg_wdata;
        REG_END_Z:    ev_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    acc   = in_valid && !in_stall;
    fin   = in_data.final_point;
    ovf   = cnt_r >= CNT_W'(MAX_POINTS);
    n_ge1 = cnt_r != '0;
    n_ge2 = cnt_r >= CNT_W'(2);
    sv_nz = (sv_r[0] != '0) || (sv_r[1] != '0) || (sv_r[2] != '0);
    ev_nz = (ev_r[0] != '0) || (ev_r[1] != '0) || (ev_r[2] != '0);

    pt[0] = in_data.point_x;
    pt[1] = in_data.point_y;
    pt[2] = in_data.point_z;

    lcmd.shift    = acc && !ovf;
    lcmd.mode_a   = n_ge2 ? OFS_DIV6 : (sv_nz ? OFS_VEL : OFS_DIV3);
    lcmd.mode_b   = ev_nz ? OFS_VEL : OFS_DIV3;
    lcmd.interior = n_ge2;
    lcmd.ovf      = ovf;

    ctl_nxt.mask          = '0;
    ctl_nxt.mask[SLOT_AM] = !ovf && n_ge2;
    ctl_nxt.mask[SLOT_AC] = !ovf && n_ge1;
    ctl_nxt.mask[SLOT_AP] = !ovf && n_ge1;
    ctl_nxt.mask[SLOT_BM] = fin && (ovf || n_ge1);
    ctl_nxt.mask[SLOT_BC] = fin && (ovf || n_ge1);
    ctl_nxt.mask[SLOT_ST] = ovf || (!n_ge1 && fin);
    ctl_nxt.status        = ovf ? ST_TOO_MANY : ST_TOO_FEW;
    ctl_nxt.idx_a         = idx3_r - IDX_W'(3);
    ctl_nxt.idx_b         = ovf ? idx3_r - IDX_W'(3) : idx3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      idx3_r <= '0;
    end else if (acc) begin
      if (fin) begin
        cnt_r  <= '0;
        idx3_r <= '0;
      end else if (!ovf) begin
        cnt_r  <= cnt_r + CNT_W'(1);
        idx3_r <= idx3_r + IDX_W'(3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        pv_r[i] <= 1'b0;
      end
    end else if (adv) begin
      pv_r[0] <= acc;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        pv_r[i] <= pv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0] <= ctl_nxt;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    wbc_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .cmd   (lcmd),
      .point (pt[l]),
      .sv    (sv_r[l]),
      .ev    (ev_r[l]),
      .ts    (seg_time_r),
      .res   (lane_res[l])
    );
  end

  wbc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (pv_r[PIPE_DEPTH-1]),
    .head       (ctl_r[PIPE_DEPTH-1]),
    .lanes      (lane_res),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign in_stall = !adv;

  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.final_point |=> cnt_r == '0)
    else $error("point count not cleared after final point");

  a_overflow_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && ovf && !in_data.final_point |=> $stable(cnt_r) && $stable(idx3_r))
    else $error("dropped point changed the path count");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.run_end)
    else $error("status result is not the last of its request");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !ovf |=> cnt_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond limit");

endmodule

[hw/rtl/wbc_offset.sv]
// Tangent offset unit: velocity product or chord difference, rounded divide by three or six.
module wbc_offset import wbc_pkg::*; (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [1:0]                 mode,
  input  logic signed [DIFF_W-1:0]   diff,
  input  logic signed [COORD_W-1:0]  vel,
  input  logic [SEG_TIME_W-1:0]      ts,
  output logic signed [OFS_W-1:0]    ofs
);

  logic signed [SEG_TIME_W:0] ts_s;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   num_r;
  logic [1:0]                 mode_m_r;

  logic                       neg;
  logic [PROD_W-1:0]          mag_in;
  logic [PROD_W:0]            bias;
  logic [PROD_W:0]            biased;
  logic [OFS_W-1:0]           dvd;

  logic [OFS_W-1:0]           word_r [0:DIV_STAGES];
  logic [1:0]                 rem_r  [0:DIV_STAGES];
  logic                       neg_r  [0:DIV_STAGES];
  logic signed [OFS_W-1:0]    ofs_r;

  assign ts_s = $signed({1'b0, ts});
  assign prod = PROD_W'(vel) * PROD_W'(ts_s);

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_m_r <= mode;
      num_r    <= (mode == OFS_VEL) ? prod : PROD_W'(diff);
    end
  end

  always_comb begin
    neg    = num_r[PROD_W-1];
    mag_in = neg ? ~num_r : num_r;
    case (mode_m_r)
      OFS_VEL:  bias = (PROD_W+1)'(VEL_BIAS);
      OFS_DIV6: bias = (PROD_W+1)'(DIV6_BIAS);
      default:  bias = (PROD_W+1)'(DIV3_BIAS);
    endcase
    biased = {1'b0, mag_in} + bias + (PROD_W+1)'(neg);
    case (mode_m_r)
      OFS_VEL:  dvd = biased[VEL_SHIFT +: OFS_W];
      OFS_DIV6: dvd = biased[1 +: OFS_W];
      default:  dvd = biased[OFS_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r[0] <= dvd;
      rem_r[0]  <= 2'd0;
      neg_r[0]  <= neg;
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    localparam int POS = OFS_W - k * DIV_CHUNK;
    logic [DIV_CHUNK+1:0] step;
    logic [OFS_W-1:0]     word_nxt;

    always_comb begin
      step = div3_chunk(rem_r[k-1], word_r[k-1][POS +: DIV_CHUNK]);
      word_nxt = word_r[k-1];
      word_nxt[POS +: DIV_CHUNK] = step[DIV_CHUNK-1:0];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        word_r[k] <= word_nxt;
        rem_r[k]  <= step[DIV_CHUNK +: 2];
        neg_r[k]  <= neg_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ofs_r <= neg_r[DIV_STAGES] ? -$signed(word_r[DIV_STAGES]) : $signed(word_r[DIV_STAGES]);
    end
  end

  assign ofs = ofs_r;

endmodule

[hw/rtl/wbc_lane.sv]
// One coordinate lane: point window, operand select and the two tangent offset units.
module wbc_lane import wbc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  wbc_lcmd_t                  cmd,
  input  logic signed [COORD_W-1:0]  point,
  input  logic signed [COORD_W-1:0]  sv,
  input  logic signed [COORD_W-1:0]  ev,
  input  logic [SEG_TIME_W-1:0]      ts,
  output wbc_lane_t                  res
);

  logic signed [COORD_W-1:0]  p1_r;
  logic signed [COORD_W-1:0]  p2_r;

  logic signed [DIFF_W-1:0]   diff_a;
  logic signed [DIFF_W-1:0]   diff_b;

  logic [1:0]                 mode_a_r;
  logic [1:0]                 mode_b_r;
  logic signed [DIFF_W-1:0]   diff_a_r;
  logic signed [DIFF_W-1:0]   diff_b_r;
  logic signed [COORD_W-1:0]  vel_a_r;
  logic signed [COORD_W-1:0]  vel_b_r;
  logic [SEG_TIME_W-1:0]      ts_r;
  logic signed [COORD_W-1:0]  pa_r [0:OFS_LAT];
  logic signed [COORD_W-1:0]  pb_r [0:OFS_LAT];

  logic signed [OFS_W-1:0]    ofs_a;
  logic signed [OFS_W-1:0]    ofs_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= '0;
      p2_r <= '0;
    end else if (cmd.shift) begin
      p1_r <= p2_r;
      p2_r <= point;
    end
  end

  always_comb begin
    diff_a = cmd.interior ? DIFF_W'(point) - DIFF_W'(p1_r) : DIFF_W'(point) - DIFF_W'(p2_r);
    diff_b = cmd.ovf ? DIFF_W'(p2_r) - DIFF_W'(p1_r) : DIFF_W'(point) - DIFF_W'(p2_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_a_r <= cmd.mode_a;
      mode_b_r <= cmd.mode_b;
      diff_a_r <= diff_a;
      diff_b_r <= diff_b;
      vel_a_r  <= sv;
      vel_b_r  <= ev;
      ts_r     <= ts;
      pa_r[0]  <= p2_r;
      pb_r[0]  <= cmd.ovf ? p2_r : point;
    end
  end

  for (genvar i = 1; i <= OFS_LAT; i++) begin : g_delay
    always_ff @(posedge clk) begin
      if (adv) begin
        pa_r[i] <= pa_r[i-1];
        pb_r[i] <= pb_r[i-1];
      end
    end
  end

  wbc_offset u_ofs_a (
    .clk  (clk),
    .adv  (adv),
    .mode (mode_a_r),
    .diff (diff_a_r),
    .vel  (vel_a_r),
    .ts   (ts_r),
    .ofs  (ofs_a)
  );

  wbc_offset u_ofs_b (
    .clk  (clk),
    .adv  (adv),
    .mode (mode_b_r),
    .diff (diff_b_r),
    .vel  (vel_b_r),
    .ts   (ts_r),
    .ofs  (ofs_b)
  );

  always_comb begin
    res.pa = pa_r[OFS_LAT];
    res.oa = ofs_a;
    res.pb = pb_r[OFS_LAT];
    res.ob = ofs_b;
  end

endmodule

[hw/rtl/wbc_merge.sv]
// Merge stage: holds one request's lane results and sends its control points one per cycle unless stalled.
module wbc_merge import wbc_pkg::*; (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             head_valid,
  input  wbc_ctrl_t                        head,
  input  wbc_lane_t [NUM_LANES-1:0]        lanes,
  output logic                             adv,
  output logic                             out_valid,
  input  logic                             out_stall,
  output wbc_out_t                         out_data
);

  logic [NUM_SLOTS-1:0]        mask_r;
  logic [NUM_SLOTS-1:0]        mask_nxt;
  logic [NUM_SLOTS-1:0]        rest;
  logic [2:0]                  slot;
  logic                        out_load;

  logic [STAT_W-1:0]           st_r;
  logic [IDX_W-1:0]            idx_a_r;
  logic [IDX_W-1:0]            idx_b_r;
  wbc_lane_t [NUM_LANES-1:0]   lane_r;

  logic                        out_valid_r;
  wbc_out_t                    out_data_r;
  wbc_out_t                    out_nxt;

  logic signed [SUM_W-1:0]     sum   [NUM_LANES];
  logic signed [COORD_W-1:0]   coord [NUM_LANES];

  always_comb begin
    slot     = first_slot(mask_r);
    rest     = mask_r & ~(NUM_SLOTS'(1) << slot);
    out_load = (|mask_r) && (!out_valid_r || !out_stall);
    adv      = !(|mask_r) || (out_load && !(|rest));
    if (adv) begin
      mask_nxt = head_valid ? head.mask : '0;
    end else if (out_load) begin
      mask_nxt = rest;
    end else begin
      mask_nxt = mask_r;
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      case (slot)
        SLOT_AM: sum[l] = SUM_W'(lane_r[l].pa) - SUM_W'(lane_r[l].oa);
        SLOT_AC: sum[l] = SUM_W'(lane_r[l].pa);
        SLOT_AP: sum[l] = SUM_W'(lane_r[l].pa) + SUM_W'(lane_r[l].oa);
        SLOT_BM: sum[l] = SUM_W'(lane_r[l].pb) - SUM_W'(lane_r[l].ob);
        SLOT_BC: sum[l] = SUM_W'(lane_r[l].pb);
        default: sum[l] = '0;
      endcase
      coord[l] = sat32(sum[l]);
    end
    out_nxt.ctrl_x  = coord[0];
    out_nxt.ctrl_y  = coord[1];
    out_nxt.ctrl_z  = coord[2];
    out_nxt.run_end = !(|rest);
    out_nxt.status  = ST_OK;
    case (slot)
      SLOT_AM: out_nxt.ctrl_index = idx_a_r - IDX_W'(1);
      SLOT_AC: out_nxt.ctrl_index = idx_a_r;
      SLOT_AP: out_nxt.ctrl_index = idx_a_r + IDX_W'(1);
      SLOT_BM: out_nxt.ctrl_index = idx_b_r - IDX_W'(1);
      SLOT_BC: out_nxt.ctrl_index = idx_b_r;
      SLOT_ST: begin
        out_nxt.ctrl_index = '0;
        out_nxt.status     = st_r;
      end
      default: out_nxt.ctrl_index = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r    <= head.status;
      idx_a_r <= head.idx_a;
      idx_b_r <= head.idx_b;
      lane_r  <= lanes;
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
